// ===== design/scpba_pkg.sv =====
// shared types, codes and constants for the size-class packet buffer allocator
// no dependencies
`default_nettype none

package scpba_pkg;

  // block handle space: 32-byte granules over a 64 KiB window
  localparam int HANDLE_W   = 11;
  localparam int NUM_BLOCKS = 2048;
  localparam int HEAP_W     = 17;
  localparam int CAP_W      = 14;
  localparam int CLS_W      = 4;

  // heap geometry
  localparam int HEAP_BYTES = 65536;
  localparam int HDR_BYTES  = 16;
  localparam int HEAP_LIMIT = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

  // request modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_RETAIN = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_NO_CLASS  = 3'd1;
  localparam logic [2:0] ST_HEAP_FULL = 3'd2;
  localparam logic [2:0] ST_REF_DROP  = 3'd3;
  localparam logic [2:0] ST_TO_LIST   = 3'd4;
  localparam logic [2:0] ST_TO_HEAP   = 3'd5;
  localparam logic [2:0] ST_REF_ADD   = 3'd6;

  // link coding: msb set means empty list / end of chain
  localparam logic [11:0] LINK_EMPTY = 12'h800;
  localparam logic [7:0]  REF_MAX    = 8'hff;

  // per-block metadata word
  typedef struct packed {
    logic [11:0] link;
    logic [3:0]  cls;
    logic [7:0]  refs;
    logic [7:0]  flags;
  } meta_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new request word
    logic exec;   // commit the request and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_result;  // captured request is the unused mode
  } dp_stat_t;

  function automatic logic [16:0] class_bytes(input logic [3:0] k);
    class_bytes = 17'd32 << k;
  endfunction

endpackage

`default_nettype wire

// ===== design/scpba_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module scpba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/scpba_ctrl.sv =====
// request sequencer and result-valid tracking for the allocator
// depends on scpba_pkg
`default_nettype none

module scpba_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire scpba_pkg::dp_stat_t stat,
  output scpba_pkg::cmd_t          cmd
);

  import scpba_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.no_result) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/scpba_dp.sv =====
// allocator datapath: class lookup, list heads, heap top, metadata ram, result register
// depends on scpba_pkg and scpba_ram
`default_nettype none

module scpba_dp #(
  parameter int NUM_CLASSES = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scpba_pkg::cmd_t     cmd,
  output scpba_pkg::dp_stat_t      stat,
  input  wire logic [1:0]          mode,
  input  wire logic [15:0]         req_size,
  input  wire logic [10:0]         block_handle,
  input  wire logic [7:0]          pkt_flags,
  output logic      [2:0]          status,
  output logic      [10:0]         handle_out,
  output logic      [13:0]         capacity,
  output logic      [3:0]          size_class,
  output logic      [16:0]         heap_used
);

  import scpba_pkg::*;

  localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  // list heads and heap top
  logic [11:0]         class_head [NUM_CLASSES];
  logic [HEAP_W-1:0]   heap_top;

  // captured request
  logic [1:0]          mode_q;
  logic [3:0]          k_q;
  logic                none_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [7:0]          flags_q;
  logic [HANDLE_W-1:0] addr_q;

  // request-side class search
  logic [16:0]         total_in;
  logic [3:0]          k_in;
  logic                none_in;
  logic [11:0]         head_in;
  logic [HANDLE_W-1:0] addr_in;
  logic [HANDLE_W-1:0] rd_addr;

  // metadata ram
  logic [$bits(meta_t)-1:0] rd_raw;
  meta_t                    rd;
  logic                     wr_en;
  logic [HANDLE_W-1:0]      wr_addr;
  meta_t                    wr_meta;

  // execute-stage results
  logic [11:0]         head_cur;
  logic [16:0]         alloc_len;
  logic                alloc_fit;
  logic [3:0]          sc;
  logic [16:0]         free_len;
  logic                at_top;
  logic                head_we;
  logic [CIDX_W-1:0]   head_idx;
  logic [11:0]         head_val;
  logic [HEAP_W-1:0]   heap_next;
  logic [2:0]          st_c;
  logic [10:0]         hout_c;
  logic [13:0]         cap_c;
  logic [3:0]          cls_c;
  logic                got;

  always_comb begin
    total_in = 17'(req_size) + 17'(HDR_BYTES);
    k_in     = 4'(NUM_CLASSES - 1);
    none_in  = 1'b1;
    for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
      if (total_in < class_bytes(4'(j))) begin
        k_in    = 4'(j);
        none_in = 1'b0;
      end
    end
    head_in = class_head[k_in[CIDX_W-1:0]];
    addr_in = (mode == MODE_ALLOC) ? head_in[10:0] : block_handle;
    rd_addr = cmd.load ? addr_in : addr_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      k_q      <= k_in;
      none_q   <= none_in;
      handle_q <= block_handle;
      flags_q  <= pkt_flags;
      addr_q   <= addr_in;
    end
  end

  scpba_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (NUM_BLOCKS)
  ) u_meta_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_raw),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_meta)
  );

  assign rd             = meta_t'(rd_raw);
  assign stat.no_result = (mode_q == MODE_NONE);

  always_comb begin
    head_cur  = class_head[k_q[CIDX_W-1:0]];
    alloc_len = class_bytes(k_q);
    alloc_fit = (18'(alloc_len) + 18'(heap_top)) < 18'(HEAP_LIMIT);
    sc        = (rd.cls >= 4'(NUM_CLASSES)) ? 4'(NUM_CLASSES - 1) : rd.cls;
    free_len  = class_bytes(sc);
    at_top    = (18'({handle_q, 5'b0}) + 18'(free_len)) == 18'(heap_top);

    wr_en     = 1'b0;
    wr_addr   = handle_q;
    wr_meta   = rd;
    head_we   = 1'b0;
    head_idx  = sc[CIDX_W-1:0];
    head_val  = head_cur;
    heap_next = heap_top;
    st_c      = ST_ALLOCATED;
    hout_c    = '0;
    cap_c     = '0;
    cls_c     = '0;
    got       = 1'b0;

    case (mode_q)
      MODE_ALLOC: begin
        if (none_q) begin
          st_c = ST_NO_CLASS;
        end else begin
          cls_c = k_q;
          if (!head_cur[11]) begin
            // pop the class list
            hout_c   = head_cur[10:0];
            head_we  = 1'b1;
            head_idx = k_q[CIDX_W-1:0];
            head_val = rd.link;
            got      = 1'b1;
          end else if (alloc_fit) begin
            // bump the heap top
            hout_c    = heap_top[15:5];
            heap_next = heap_top + alloc_len;
            got       = 1'b1;
          end else begin
            st_c = ST_HEAP_FULL;
          end
          if (got) begin
            wr_en         = 1'b1;
            wr_addr       = hout_c;
            wr_meta.link  = LINK_EMPTY;
            wr_meta.cls   = k_q;
            wr_meta.refs  = '0;
            wr_meta.flags = flags_q;
            cap_c         = 14'(alloc_len - 17'(HDR_BYTES));
            st_c          = ST_ALLOCATED;
          end
        end
      end
      MODE_FREE: begin
        cls_c = sc;
        wr_en = 1'b1;
        if (rd.refs != 8'd0) begin
          wr_meta.refs = rd.refs - 8'd1;
          st_c         = ST_REF_DROP;
        end else if (at_top) begin
          heap_next = heap_top - free_len;
          wr_meta   = '0;
          st_c      = ST_TO_HEAP;
        end else begin
          // push onto the class list
          wr_meta.link = class_head[sc[CIDX_W-1:0]];
          head_we      = 1'b1;
          head_idx     = sc[CIDX_W-1:0];
          head_val     = {1'b0, handle_q};
          st_c         = ST_TO_LIST;
        end
      end
      MODE_RETAIN: begin
        cls_c = sc;
        wr_en = 1'b1;
        if (rd.refs != REF_MAX) begin
          wr_meta.refs = rd.refs + 8'd1;
        end
        st_c = ST_REF_ADD;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase

    if (!cmd.exec) begin
      wr_en   = 1'b0;
      head_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_top <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_head[i] <= LINK_EMPTY;
      end
    end else if (cmd.exec) begin
      heap_top <= heap_next;
      if (head_we) begin
        class_head[head_idx] <= head_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= st_c;
      handle_out <= hout_c;
      capacity   <= cap_c;
      size_class <= cls_c;
      heap_used  <= heap_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/size_class_packet_buffer_allocator.sv =====
// top level of the size-class packet buffer allocator
// depends on scpba_pkg, scpba_ctrl, scpba_dp (which holds scpba_ram)
`default_nettype none

// Packet buffer allocator with power-of-two size classes (32 bytes and up,
// one class per NUM_CLASSES) carved from a bump heap of at most 64 KiB.
// A request word is allocate, drop one reference, or add one reference;
// each gives one result word, except the unused mode which gives none.
// Blocks are named by their start in 32-byte granules. Allocate pops the
// smallest fitting class list or bumps the heap top; a block freed at zero
// references falls back to the heap when it ends at the top, otherwise it is
// pushed onto its class list. Per-block metadata (link, class, reference
// count, flag byte) lives in one 2048-entry ram with registered read, and is
// undefined until a block is first allocated: freeing or retaining a handle
// never handed out gives unspecified results. There is no clearing pass, the
// block is ready right after reset. In the accept cycle the class is found
// and the metadata read is issued; in the commit that follows, once the
// result register is free, the read data is modified and written back, the
// list head and heap top update and the result register loads. A new request
// waits for the previous commit, set by that read-modify-write on the metadata
// ram. The result register frees the input side: a new request is accepted
// while the previous result still waits for out_ready.

module size_class_packet_buffer_allocator #(
  parameter int NUM_CLASSES = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] req_size,
  input  wire logic [10:0] block_handle,
  input  wire logic [7:0]  pkt_flags,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  status,
  output logic      [10:0] handle_out,
  output logic      [13:0] capacity,
  output logic      [3:0]  size_class,
  output logic      [16:0] heap_used
);

  import scpba_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // sequencer: accept, then commit when the result register is free
  scpba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // class search, list heads, heap top, metadata ram and result register
  scpba_dp #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .req_size     (req_size),
    .block_handle (block_handle),
    .pkt_flags    (pkt_flags),
    .status       (status),
    .handle_out   (handle_out),
    .capacity     (capacity),
    .size_class   (size_class),
    .heap_used    (heap_used)
  );

  // heap top only ever moves by whole granules
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heap_used[4:0] == 5'd0))
    else $error("heap top not granule aligned");

  // a request with no fitting class carries no block
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NO_CLASS) |->
      (handle_out == 11'd0 && capacity == 14'd0 && size_class == 4'd0))
    else $error("no-class result carries block data");

  // commit never overlaps accepting a new request
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !in_ready)
    else $error("commit while accepting");

  // a committed result is presented on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("committed result not presented");

endmodule

`default_nettype wire
